>>> design/disk_stats_rate_extractor_core_assert.svh
// Assertion macros shared by the disk statistics rate extractor modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef DISK_STATS_RATE_EXTRACTOR_CORE_ASSERT_SVH
`define DISK_STATS_RATE_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSRE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSRE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/dsre_pkg.sv
// Package of the disk statistics rate extractor: constants, types and helpers.
// Used by every module of the block and by the output and configuration interfaces; depends on nothing.
package dsre_pkg;

  // Sizes of the data path.
  localparam int SECTOR_BYTES   = 512;
  localparam int MAX_NAME_CHARS = 8;
  localparam int VALUE_W        = 32;
  localparam int BYTES_W        = VALUE_W + $clog2(SECTOR_BYTES);
  localparam int DVD_W          = 64;
  localparam int DIV_STEPS      = DVD_W;
  localparam int STEP_W         = $clog2(DIV_STEPS);
  localparam int POS_W          = 4;
  localparam int FIELD_W        = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;

  // Field numbers and characters of interest.
  localparam logic [FIELD_W-1:0] FIELD_READ  = 3'd3;
  localparam logic [FIELD_W-1:0] FIELD_WRITE = 3'd7;
  localparam logic [7:0]         CHAR_SPACE  = 8'h20;
  localparam logic [7:0]         CHAR_ZERO   = 8'h30;
  localparam logic [7:0]         CHAR_NINE   = 8'h39;

  // Reset values of the configuration registers ("sda", 3 chars, 3 s).
  localparam logic [63:0] DEVICE_NAME_RST   = 64'h0000_0000_0061_6473;
  localparam logic [3:0]  NAME_LENGTH_RST   = 4'd3;
  localparam logic [7:0]  INTERVAL_RST      = 8'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_NAME = 2'd0,
    REG_NAME_LENGTH = 2'd1,
    REG_INTERVAL    = 2'd2
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_DELIVER
  } ctrl_state_e;

  typedef struct packed {
    logic [63:0] device_name;
    logic [3:0]  name_length;
    logic [7:0]  interval;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_req;
    logic out_free;
  } ctrl_status_t;

  // State of one restoring divider.
  typedef struct packed {
    logic [7:0]       rem;
    logic [DVD_W-1:0] dvd;
  } div_state_t;

  // One step of a restoring divider: the dividend shifts out at the top and
  // the quotient bits shift in at the bottom.
  function automatic div_state_t div_step(div_state_t s, logic [7:0] divisor);
    logic [8:0] trial;
    div_state_t r;
    trial = {s.rem, s.dvd[DVD_W-1]};
    r.dvd = {s.dvd[DVD_W-2:0], 1'b0};
    if (trial >= {1'b0, divisor}) begin
      trial    = trial - {1'b0, divisor};
      r.dvd[0] = 1'b1;
    end
    r.rem = trial[7:0];
    return r;
  endfunction

  // Decimal accumulation with saturation at the top of 32 bits.
  function automatic logic [VALUE_W-1:0] add_digit(logic [VALUE_W-1:0] acc,
                                                   logic [3:0] digit);
    logic [VALUE_W+3:0] v;
    v = {acc, 3'b000} + {3'b000, acc, 1'b0} + (VALUE_W+4)'(digit);
    return (v[VALUE_W+3:VALUE_W] != '0) ? '1 : v[VALUE_W-1:0];
  endfunction

endpackage

>>> design/dsre_in_if.sv
// Input channel of the rate extractor: one text byte per word.
// Depends on nothing.
interface dsre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       snapshot_start;

  modport source (output valid, output text_byte, output snapshot_start, input ready);
  modport sink (input valid, input text_byte, input snapshot_start, output ready);
endinterface

>>> design/dsre_out_if.sv
// Output channel of the rate extractor: read and write byte rates per word.
// Depends on dsre_pkg.
interface dsre_out_if;
  logic                         valid;
  logic                         ready;
  logic [dsre_pkg::VALUE_W-1:0] read_rate;
  logic [dsre_pkg::VALUE_W-1:0] write_rate;

  modport source (output valid, output read_rate, output write_rate, input ready);
  modport sink (input valid, input read_rate, input write_rate, output ready);
endinterface

>>> design/dsre_cfg_if.sv
// Configuration write channel of the rate extractor: register index and data.
// Depends on dsre_pkg.
interface dsre_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dsre_pkg::CFG_IDX_W-1:0]  index;
  logic [dsre_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/dsre_cfg_regs.sv
// Configuration registers of the rate extractor.
// Depends on dsre_pkg and dsre_cfg_if.
module dsre_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  dsre_cfg_if.sink         cfg_i,
  output dsre_pkg::cfg_t   cfg_o
);

  dsre_pkg::cfg_t cfg_q;

  // Writes are always taken; an index beyond the list is dropped.
  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_name <= dsre_pkg::DEVICE_NAME_RST;
      cfg_q.name_length <= dsre_pkg::NAME_LENGTH_RST;
      cfg_q.interval    <= dsre_pkg::INTERVAL_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        dsre_pkg::REG_DEVICE_NAME: cfg_q.device_name <= cfg_i.data;
        dsre_pkg::REG_NAME_LENGTH: cfg_q.name_length <= cfg_i.data[3:0];
        dsre_pkg::REG_INTERVAL:    cfg_q.interval    <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/dsre_ctrl.sv
// Controller of the rate extractor: byte intake, divider sequencing, delivery.
// Depends on dsre_pkg and the assertion macro header.
`include "disk_stats_rate_extractor_core_assert.svh"

module dsre_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dsre_pkg::ctrl_status_t status_i,
  output dsre_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic [dsre_pkg::STEP_W-1:0] STEP_LAST =
    dsre_pkg::STEP_W'(dsre_pkg::DIV_STEPS - 1);

  dsre_pkg::ctrl_state_e         state_q, state_d;
  logic [dsre_pkg::STEP_W-1:0]   cnt_q, cnt_d;

  // State and step counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsre_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      dsre_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.emit_req) begin
            state_d = dsre_pkg::ST_LOAD;
          end
        end
      end
      dsre_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = dsre_pkg::ST_DIVIDE;
      end
      dsre_pkg::ST_DIVIDE: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == STEP_LAST) begin
          state_d = dsre_pkg::ST_DELIVER;
        end
      end
      dsre_pkg::ST_DELIVER: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = dsre_pkg::ST_IDLE;
        end
      end
      default: state_d = dsre_pkg::ST_IDLE;
    endcase
  end

  `DSRE_ASSERT_NXT(a_load_starts_divide, clk_i, rst_ni, state_q == dsre_pkg::ST_LOAD,
    state_q == dsre_pkg::ST_DIVIDE && cnt_q == '0, "divider did not start at step zero")
  `DSRE_ASSERT_NXT(a_divide_runs_full, clk_i, rst_ni,
    state_q == dsre_pkg::ST_DIVIDE && cnt_q != STEP_LAST,
    state_q == dsre_pkg::ST_DIVIDE, "divider left before its last step")
  `DSRE_ASSERT_NXT(a_deliver_waits, clk_i, rst_ni,
    state_q == dsre_pkg::ST_DELIVER && !status_i.out_free,
    state_q == dsre_pkg::ST_DELIVER, "result dropped while output register busy")

endmodule

>>> design/dsre_datapath.sv
// Datapath of the rate extractor: name matcher, field parser, byte totals,
// two bit-serial dividers and the output register. Depends on dsre_pkg.
`include "disk_stats_rate_extractor_core_assert.svh"

module dsre_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dsre_pkg::cfg_t                  cfg_i,
  input  logic [7:0]                      text_byte_i,
  input  logic                            snapshot_start_i,
  input  dsre_pkg::ctrl_cmd_t             cmd_i,
  output dsre_pkg::ctrl_status_t          status_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dsre_pkg::VALUE_W-1:0]    read_rate_o,
  output logic [dsre_pkg::VALUE_W-1:0]    write_rate_o
);

  localparam int BW = dsre_pkg::BYTES_W;

  // Parser state.
  logic [dsre_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [dsre_pkg::FIELD_W-1:0] fc_q, fc_d;
  logic [dsre_pkg::VALUE_W-1:0] rs_q, rs_d, ws_q, ws_d;
  logic                         fin_q, fin_d;
  // Totals of the previous snapshot.
  logic [BW-1:0]                prev_rd_q, prev_wr_q;
  logic                         have_prev_q;
  // Divider and result.
  logic [BW-1:0]                rb_q, wb_q;
  dsre_pkg::div_state_t         rd_div_q, wr_div_q;
  logic [7:0]                   divisor_q;
  logic                         out_valid_q;
  logic [dsre_pkg::VALUE_W-1:0] out_rd_q, out_wr_q;

  // Parser values seen by this byte: a snapshot start clears them first.
  logic [dsre_pkg::POS_W-1:0]   cur_pos;
  logic [dsre_pkg::FIELD_W-1:0] cur_fc;
  logic [dsre_pkg::VALUE_W-1:0] cur_rs, cur_ws;
  logic                         cur_fin;
  logic [dsre_pkg::POS_W-1:0]   eff_len;
  logic [7:0]                   want;
  logic                         in_name, is_space, is_digit, emit_req;
  logic [3:0]                   digit;

  assign cur_pos = snapshot_start_i ? '0 : pos_q;
  assign cur_fc  = snapshot_start_i ? '0 : fc_q;
  assign cur_rs  = snapshot_start_i ? '0 : rs_q;
  assign cur_ws  = snapshot_start_i ? '0 : ws_q;
  assign cur_fin = snapshot_start_i ? 1'b0 : fin_q;

  // Name length clamped to 1..MAX_NAME_CHARS.
  always_comb begin
    eff_len = cfg_i.name_length;
    if (eff_len == '0) begin
      eff_len = 4'd1;
    end else if (eff_len > dsre_pkg::POS_W'(dsre_pkg::MAX_NAME_CHARS)) begin
      eff_len = dsre_pkg::POS_W'(dsre_pkg::MAX_NAME_CHARS);
    end
  end

  assign want     = cfg_i.device_name[{cur_pos[2:0], 3'b000} +: 8];
  assign in_name  = cur_pos < eff_len;
  assign is_space = text_byte_i == dsre_pkg::CHAR_SPACE;
  assign is_digit = text_byte_i >= dsre_pkg::CHAR_ZERO && text_byte_i <= dsre_pkg::CHAR_NINE;
  assign digit    = 4'(text_byte_i - dsre_pkg::CHAR_ZERO);
  assign emit_req = !cur_fin && !in_name && is_space && cur_fc == dsre_pkg::FIELD_WRITE;

  assign status_o.emit_req = emit_req;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Parser next state for one accepted byte.
  always_comb begin
    pos_d = cur_pos;
    fc_d  = cur_fc;
    rs_d  = cur_rs;
    ws_d  = cur_ws;
    fin_d = cur_fin;
    if (!cur_fin) begin
      if (in_name) begin
        pos_d = (text_byte_i == want) ? cur_pos + 1'b1 : '0;
      end else if (is_space) begin
        if (cur_fc == dsre_pkg::FIELD_WRITE) begin
          fin_d = 1'b1;
        end else begin
          fc_d = cur_fc + 1'b1;
        end
      end else if (is_digit) begin
        if (cur_fc == dsre_pkg::FIELD_READ) begin
          rs_d = dsre_pkg::add_digit(cur_rs, digit);
        end else if (cur_fc == dsre_pkg::FIELD_WRITE) begin
          ws_d = dsre_pkg::add_digit(cur_ws, digit);
        end
      end
    end
  end

  // Control and kept state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fc_q        <= '0;
      rs_q        <= '0;
      ws_q        <= '0;
      fin_q       <= 1'b0;
      prev_rd_q   <= '0;
      prev_wr_q   <= '0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        pos_q <= pos_d;
        fc_q  <= fc_d;
        rs_q  <= rs_d;
        ws_q  <= ws_d;
        fin_q <= fin_d;
      end
      if (cmd_i.load) begin
        prev_rd_q   <= rb_q;
        prev_wr_q   <= wb_q;
        have_prev_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sector to byte conversion, divider loading and iteration, result capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && emit_req) begin
      rb_q <= BW'(BW'(cur_rs) * BW'(dsre_pkg::SECTOR_BYTES));
      wb_q <= BW'(BW'(cur_ws) * BW'(dsre_pkg::SECTOR_BYTES));
    end
    if (cmd_i.load) begin
      rd_div_q.rem <= '0;
      wr_div_q.rem <= '0;
      rd_div_q.dvd <= have_prev_q ? dsre_pkg::DVD_W'(rb_q) - dsre_pkg::DVD_W'(prev_rd_q) : '0;
      wr_div_q.dvd <= have_prev_q ? dsre_pkg::DVD_W'(wb_q) - dsre_pkg::DVD_W'(prev_wr_q) : '0;
      divisor_q    <= (cfg_i.interval == '0) ? 8'd1 : cfg_i.interval;
    end else if (cmd_i.step) begin
      rd_div_q <= dsre_pkg::div_step(rd_div_q, divisor_q);
      wr_div_q <= dsre_pkg::div_step(wr_div_q, divisor_q);
    end
    if (cmd_i.emit) begin
      out_rd_q <= rd_div_q.dvd[dsre_pkg::VALUE_W-1:0];
      out_wr_q <= wr_div_q.dvd[dsre_pkg::VALUE_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_rate_o  = out_rd_q;
  assign write_rate_o = out_wr_q;

  `DSRE_ASSERT_IMP(a_pos_in_range, clk_i, rst_ni, 1'b1,
    pos_q <= dsre_pkg::POS_W'(dsre_pkg::MAX_NAME_CHARS), "name position beyond name")
  `DSRE_ASSERT_NXT(a_emit_finishes, clk_i, rst_ni, cmd_i.accept && emit_req,
    fin_q, "snapshot not marked finished after field seven")
  `DSRE_ASSERT_NXT(a_load_keeps_totals, clk_i, rst_ni, cmd_i.load,
    have_prev_q && prev_rd_q == $past(rb_q) && prev_wr_q == $past(wb_q),
    "previous totals not kept on divider load")

endmodule

>>> design/disk_stats_rate_extractor_core.sv
// Disk statistics rate extractor. Scans snapshot text one byte per word and
// emits read and write byte rates per second for one configured device. A
// byte is taken every cycle, except the space that ends field 7 of the
// matched line: the block captures the byte totals as it takes that space,
// then loads two 64-bit restoring dividers, runs them bit-serially and
// hands the rates to the output register; input pauses through the load,
// divide and deliver states, including any wait for the output register to
// be emptied. Bytes after that space are absorbed at full rate until the next
// snapshot start. Depends on dsre_pkg, the channel interfaces and the
// submodules.
module disk_stats_rate_extractor_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsre_cfg_if.sink  cfg_i,
  dsre_in_if.sink   in_i,
  dsre_out_if.source out_o
);

  dsre_pkg::cfg_t          cfg;
  dsre_pkg::ctrl_cmd_t     cmd;
  dsre_pkg::ctrl_status_t  status;

  // Configuration registers.
  dsre_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Sequencer.
  dsre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Parser, dividers and output register.
  dsre_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .text_byte_i      (in_i.text_byte),
    .snapshot_start_i (in_i.snapshot_start),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .read_rate_o      (out_o.read_rate),
    .write_rate_o     (out_o.write_rate)
  );

endmodule

>>> tb/sv/disk_stats_rate_extractor_core_test.sv
`timescale 1ns / 100ps
// Self-checking test of the disk statistics rate extractor: streams snapshot text,
// predicts read and write byte rates, and checks every output word in order.
// Depends on dsre_pkg, the three channel interfaces and the core module.
module disk_stats_rate_extractor_core_test;

  typedef struct {
    logic [7:0] text_byte;
    logic       snapshot_start;
  } text_word_t;

  typedef struct {
    logic [31:0] read_rate;
    logic [31:0] write_rate;
  } rate_pair_t;

  logic clk;
  logic rst_n;

  dsre_cfg_if cfg_ch ();
  dsre_in_if  text_ch ();
  dsre_out_if rate_ch ();

  disk_stats_rate_extractor_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (text_ch),
    .out_o  (rate_ch)
  );

  // Words waiting to be sent and rates waiting to come out.
  text_word_t  text_pending[$];
  rate_pair_t  rates_due[$];

  // Mirror of the configuration registers.
  logic [63:0] name_cfg     = dsre_pkg::DEVICE_NAME_RST;
  logic [3:0]  len_cfg      = dsre_pkg::NAME_LENGTH_RST;
  logic [7:0]  interval_cfg = dsre_pkg::INTERVAL_RST;

  // Mirror of the parser and rate state.
  logic [3:0]  match_pos;
  logic [2:0]  fields_done;
  logic [31:0] read_sectors;
  logic [31:0] write_sectors;
  logic [63:0] last_read_bytes;
  logic [63:0] last_write_bytes;
  logic        have_last;
  logic        line_done;

  int unsigned idle_odds;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned mismatches;
  logic        in_taken;

  initial begin
    match_pos        = '0;
    fields_done      = '0;
    read_sectors     = '0;
    write_sectors    = '0;
    last_read_bytes  = '0;
    last_write_bytes = '0;
    have_last        = 1'b0;
    line_done        = 1'b0;
    idle_odds        = 0;
    gap_left         = 0;
    stall_left       = 0;
    mismatches       = 0;
    in_taken         = 1'b0;
  end

  // Number of name characters actually compared for a length register value.
  function automatic int unsigned name_chars(logic [3:0] n);
    if (n == 0) return 1;
    if (n > dsre_pkg::MAX_NAME_CHARS) return dsre_pkg::MAX_NAME_CHARS;
    return n;
  endfunction

  // Decimal accumulation that sticks at the 32-bit maximum.
  function automatic logic [31:0] add_decimal(logic [31:0] acc, logic [7:0] ch);
    logic [63:0] v;
    v = 64'(acc) * 64'd10 + 64'(ch - dsre_pkg::CHAR_ZERO);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Advances the parser by one text byte; returns 1 when a rate pair comes out.
  function automatic bit parse_stat_byte(input logic [7:0] ch, input logic start,
                                         output rate_pair_t rates);
    logic [63:0] rd_bytes;
    logic [63:0] wr_bytes;
    logic [63:0] divisor;
    rates = '{32'd0, 32'd0};
    if (start) begin
      match_pos     = '0;
      fields_done   = '0;
      read_sectors  = '0;
      write_sectors = '0;
      line_done     = 1'b0;
    end
    if (line_done) return 0;

    // Device name search; a mismatching byte is not compared again.
    if (match_pos < name_chars(len_cfg)) begin
      match_pos = (ch == name_cfg[8*match_pos[2:0] +: 8]) ? match_pos + 4'd1 : 4'd0;
      return 0;
    end

    if (ch == dsre_pkg::CHAR_SPACE) begin
      if (fields_done >= dsre_pkg::FIELD_WRITE) begin
        rd_bytes = 64'(read_sectors) * 64'(dsre_pkg::SECTOR_BYTES);
        wr_bytes = 64'(write_sectors) * 64'(dsre_pkg::SECTOR_BYTES);
        divisor  = (interval_cfg == 0) ? 64'd1 : 64'(interval_cfg);
        if (have_last) begin
          rates.read_rate  = 32'((rd_bytes - last_read_bytes) / divisor);
          rates.write_rate = 32'((wr_bytes - last_write_bytes) / divisor);
        end
        have_last        = 1'b1;
        last_read_bytes  = rd_bytes;
        last_write_bytes = wr_bytes;
        line_done        = 1'b1;
        return 1;
      end
      fields_done = fields_done + 3'd1;
      return 0;
    end

    if (ch >= dsre_pkg::CHAR_ZERO && ch <= dsre_pkg::CHAR_NINE) begin
      if (fields_done == dsre_pkg::FIELD_READ) begin
        read_sectors = add_decimal(read_sectors, ch);
      end else if (fields_done == dsre_pkg::FIELD_WRITE) begin
        write_sectors = add_decimal(write_sectors, ch);
      end
    end
    return 0;
  endfunction

  function automatic void log_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want_v, got_v);
  endfunction

  function automatic void queue_byte(logic [7:0] ch, logic start);
    text_pending.push_back('{ch, start});
  endfunction

  function automatic void queue_text(string s, logic start_first);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], start_first && i == 0);
  endfunction

  function automatic logic [7:0] nonspace_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    return (b >= dsre_pkg::CHAR_SPACE) ? b + 8'd1 : b;
  endfunction

  // Builds one snapshot line, mostly well formed, sometimes broken; returns its length.
  function automatic int unsigned queue_snapshot(logic [63:0] nm, logic [3:0] len_reg);
    logic [7:0]  line[$];
    int unsigned len;
    int unsigned flavor;
    int unsigned ndig;
    int unsigned cut;
    int unsigned stray;
    len    = name_chars(len_reg);
    flavor = $urandom_range(0, 19);

    // Text ahead of the name: letters, raw bytes, or a name prefix cut short.
    case ($urandom_range(0, 3))
      1: repeat ($urandom_range(1, 4)) line.push_back(8'($urandom_range(8'h61, 8'h7a)));
      2: repeat ($urandom_range(1, 6)) line.push_back(8'($urandom_range(0, 255)));
      3: begin
        cut = $urandom_range(0, len - 1);
        for (int i = 0; i < cut; i++) line.push_back(nm[8*i +: 8]);
        line.push_back(dsre_pkg::CHAR_SPACE);
      end
      default: ;
    endcase

    if (flavor == 18) begin
      // Line with no name at all.
      repeat ($urandom_range(4, 20)) line.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < len; i++) line.push_back(nm[8*i +: 8]);
      if (flavor == 15)
        line[line.size() - 1 - $urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
      // Fields 0 to 7; the sector counts sometimes run long enough to saturate.
      for (int f = 0; f < 8; f++) begin
        if (f == dsre_pkg::FIELD_READ || f == dsre_pkg::FIELD_WRITE) begin
          ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 7);
          repeat (ndig) begin
            if ($urandom_range(0, 15) == 0) line.push_back(nonspace_byte());
            line.push_back(dsre_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
          end
        end else begin
          repeat ($urandom_range(0, 2)) line.push_back(nonspace_byte());
        end
        line.push_back(dsre_pkg::CHAR_SPACE);
      end
      repeat ($urandom_range(0, 6)) line.push_back(8'($urandom_range(0, 255)));
    end

    if (flavor == 16) begin
      cut = $urandom_range(0, line.size() - 1);
      while (line.size() > cut + 1) void'(line.pop_back());
    end
    stray = (flavor == 19) ? $urandom_range(1, line.size() - 1) : 0;
    foreach (line[i]) queue_byte(line[i], (i == 0 && flavor != 17) || (stray != 0 && i == stray));
    return line.size();
  endfunction

  task automatic write_reg(dsre_pkg::cfg_reg_e idx, logic [63:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Waits for the sender to empty, all rates to arrive, then for the block to settle.
  task automatic drain_block();
    while (text_pending.size() != 0 || text_ch.valid) @(posedge clk);
    while (rates_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Text sender: one word per handshake, with random gap bursts.
  always @(negedge clk) begin
    text_word_t w;
    if (rst_n && (!text_ch.valid || in_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        text_ch.valid <= 1'b0;
      end else if (idle_odds != 0 && $urandom % idle_odds == 0) begin
        gap_left = $urandom_range(0, 9);
        text_ch.valid <= 1'b0;
      end else if (text_pending.size() != 0) begin
        w = text_pending.pop_front();
        text_ch.valid          <= 1'b1;
        text_ch.text_byte      <= w.text_byte;
        text_ch.snapshot_start <= w.snapshot_start;
      end else begin
        text_ch.valid <= 1'b0;
      end
    end
  end

  // Rate receiver back-pressure in random stall bursts.
  always @(negedge clk) begin
    if (idle_odds == 0) begin
      rate_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      rate_ch.ready <= 1'b0;
    end else if ($urandom % idle_odds == 0) begin
      stall_left = $urandom_range(0, 9);
      rate_ch.ready <= 1'b0;
    end else begin
      rate_ch.ready <= 1'b1;
    end
  end

  // Monitor: checks output words, tracks register writes, predicts from accepted text.
  always @(posedge clk) begin
    rate_pair_t got;
    rate_pair_t want;
    rate_pair_t next_rates;
    if (rst_n) begin
      if (rate_ch.valid && rate_ch.ready) begin
        got = '{rate_ch.read_rate, rate_ch.write_rate};
        if (rates_due.size() == 0) begin
          log_mismatch("unexpected word, read_rate", 32'd0, got.read_rate);
        end else begin
          want = rates_due.pop_front();
          if (got.read_rate !== want.read_rate)
            log_mismatch("read_rate", want.read_rate, got.read_rate);
          if (got.write_rate !== want.write_rate)
            log_mismatch("write_rate", want.write_rate, got.write_rate);
        end
      end

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (dsre_pkg::cfg_reg_e'(cfg_ch.index))
          dsre_pkg::REG_DEVICE_NAME: name_cfg     = cfg_ch.data;
          dsre_pkg::REG_NAME_LENGTH: len_cfg      = cfg_ch.data[3:0];
          dsre_pkg::REG_INTERVAL:    interval_cfg = cfg_ch.data[7:0];
          default: ;
        endcase
      end

      in_taken = text_ch.valid && text_ch.ready;
      if (in_taken && parse_stat_byte(text_ch.text_byte, text_ch.snapshot_start, next_rates)) begin
        rates_due.push_back(next_rates);
      end
    end
  end

  // Stimulus: directed lines on the reset setup, then random phases with new settings.
  initial begin
    logic [63:0] nm;
    logic [3:0]  len;
    logic [7:0]  ivl;
    int unsigned phase;
    int unsigned made;
    int unsigned random_made;

    rst_n                  = 1'b0;
    text_ch.valid          = 1'b0;
    text_ch.text_byte      = '0;
    text_ch.snapshot_start = 1'b0;
    rate_ch.ready          = 1'b1;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = dsre_pkg::REG_DEVICE_NAME;
    cfg_ch.data            = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // First snapshot gives zeros; a failed name byte is not retried; tail is ignored.
    idle_odds = 4;
    queue_text("ssdasda   7    5  9", 1'b1);
    // Line with extreme bytes and no full name: nothing comes out.
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_text("sd", 1'b0);
    queue_byte(8'hFF, 1'b0);
    // Saturated read count and a write total below the previous one.
    queue_text("sda   9999999999    0 ", 1'b1);
    drain_block();

    phase       = 1;
    random_made = 0;
    while (random_made < 800) begin
      for (int i = 0; i < 8; i++) nm[8*i +: 8] = 8'($urandom_range(8'h61, 8'h7a));
      case (phase)
        1: begin
          len = 4'd8;
          ivl = 8'd1;
        end
        2: begin
          nm  = '1;
          len = 4'd1;
          ivl = 8'd255;
        end
        3: begin
          nm  = '0;
          len = 4'd0;
          ivl = 8'd0;
        end
        4: begin
          nm  = {$urandom, $urandom};
          len = 4'd15;
          ivl = 8'($urandom_range(1, 255));
        end
        default: begin
          if ($urandom_range(0, 1) == 1) nm = {$urandom, $urandom};
          len = 4'($urandom_range(1, 8));
          ivl = 8'($urandom_range(1, 255));
        end
      endcase
      // Upper data bits beyond each register are junk and must be dropped.
      write_reg(dsre_pkg::REG_DEVICE_NAME, nm);
      write_reg(dsre_pkg::REG_NAME_LENGTH, {$urandom, $urandom} & ~64'hF | 64'(len));
      write_reg(dsre_pkg::REG_INTERVAL, {$urandom, $urandom} & ~64'hFF | 64'(ivl));

      if (random_made >= 650) idle_odds = 0;
      else begin
        case (phase % 3)
          0: idle_odds = 0;
          1: idle_odds = 3;
          default: idle_odds = 8;
        endcase
      end

      made = 0;
      while (made < 120) made += queue_snapshot(nm, len);
      random_made += made;
      drain_block();
      phase++;
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
